[rtl/core/mm_pkg.sv]
// mm_pkg: shared types and constants for the matrix multiply block
// element format, configuration register map, controller states and the
// command/status bundles between controller and datapath; no dependencies
`default_nettype none

package mm_pkg;

    // element format: signed Q16.16
    localparam int ELEM_W = 32;
    localparam int FRAC_W = 16;

    // configuration port
    localparam int CFG_W   = 3;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    // register map, one word each
    typedef enum logic [1:0] {
        CFG_LEFT_ROWS  = 2'd0,
        CFG_LEFT_COLS  = 2'd1,
        CFG_RIGHT_ROWS = 2'd2,
        CFG_RIGHT_COLS = 2'd3
    } t_cfg_idx;

    // element kind on the input
    localparam logic KIND_LEFT  = 1'b0;
    localparam logic KIND_RIGHT = 1'b1;

    // raw size registers as written
    typedef struct packed {
        logic [CFG_W-1:0] left_rows;
        logic [CFG_W-1:0] left_cols;
        logic [CFG_W-1:0] right_rows;
        logic [CFG_W-1:0] right_cols;
    } t_cfg;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_left;
        logic load_right;
        logic start_run;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic right_done;
        logic run_end;
    } t_dp_stat;

endpackage : mm_pkg

`default_nettype wire

[rtl/core/mm_regs.sv]
// mm_regs: APB-style register file holding the four matrix size registers
// depends on mm_pkg
`default_nettype none

module mm_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mm_pkg::PADDR_W-1:0]     paddr,
    input  logic [mm_pkg::PDATA_W-1:0]     pwdata,
    output logic [mm_pkg::PDATA_W-1:0]     prdata,
    output logic                           pready,
    output mm_pkg::t_cfg                   o_cfg
);
    import mm_pkg::*;

    t_cfg     r_cfg;
    t_cfg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_cfg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_rows  <= CFG_RESET;
            r_cfg.left_cols  <= CFG_RESET;
            r_cfg.right_rows <= CFG_RESET;
            r_cfg.right_cols <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                CFG_LEFT_ROWS:  r_cfg.left_rows  <= pwdata[CFG_W-1:0];
                CFG_LEFT_COLS:  r_cfg.left_cols  <= pwdata[CFG_W-1:0];
                CFG_RIGHT_ROWS: r_cfg.right_rows <= pwdata[CFG_W-1:0];
                CFG_RIGHT_COLS: r_cfg.right_cols <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            CFG_LEFT_ROWS:  prdata = PDATA_W'(r_cfg.left_rows);
            CFG_LEFT_COLS:  prdata = PDATA_W'(r_cfg.left_cols);
            CFG_RIGHT_ROWS: prdata = PDATA_W'(r_cfg.right_rows);
            CFG_RIGHT_COLS: prdata = PDATA_W'(r_cfg.right_cols);
            default:        prdata = '0;
        endcase
    end

endmodule : mm_regs

`default_nettype wire

[rtl/core/mm_ctrl.sv]
// mm_ctrl: controller state machine, loading versus product run
// depends on mm_pkg; drives the datapath through t_dp_cmd
`default_nettype none

module mm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_kind,
    input  mm_pkg::t_dp_stat   i_stat,
    output mm_pkg::t_dp_cmd    o_cmd,
    output logic               o_busy
);
    import mm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_start && (r_state == ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_kind == KIND_RIGHT) && i_stat.right_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.run_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load_left  = w_accept && (i_kind == KIND_LEFT);
                o_cmd.load_right = w_accept && (i_kind == KIND_RIGHT);
                o_cmd.start_run  = w_accept && (i_kind == KIND_RIGHT) && i_stat.right_done;
            end
            ST_RUN: begin
                o_busy     = 1'b1;
                o_cmd.step = 1'b1;
            end
            default: ;
        endcase
    end

endmodule : mm_ctrl

`default_nettype wire

[rtl/core/mm_dp.sv]
// mm_dp: element stores, load counters, term sequencer and the shared
// multiply-accumulate pipeline with saturation; depends on mm_pkg
`default_nettype none

module mm_dp #(
    parameter  int MAX_DIM = 4,
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [mm_pkg::ELEM_W-1:0]  i_value,
    input  mm_pkg::t_cfg                      i_cfg,
    input  mm_pkg::t_dp_cmd                   i_cmd,
    output mm_pkg::t_dp_stat                  o_stat,
    output logic                              o_res_valid,
    output logic signed [mm_pkg::ELEM_W-1:0]  o_value_res,
    output logic [IDX_W-1:0]                  o_row_index,
    output logic [IDX_W-1:0]                  o_col_index,
    output logic                              o_size_error,
    output logic                              o_last
);
    import mm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ACC_W  = PROD_W - FRAC_W + $clog2(MAX_DIM) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - ELEM_W + 1){1'b0}}, {(ELEM_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // a size of zero counts as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    logic [DIM_W-1:0] w_lr, w_lc, w_rr, w_rc;
    logic [CNT_W-1:0] w_ltot, w_rtot;
    logic             w_left_wr, w_right_wr;

    logic [CNT_W-1:0] r_lcount, r_rcount;

    logic signed [ELEM_W-1:0] r_left_mem  [DEPTH];
    logic signed [ELEM_W-1:0] r_right_mem [DEPTH];

    logic             r_echo;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic [IDX_W-1:0] w_lsel;
    logic [CNT_W-1:0] w_laddr_full, w_raddr_full;
    logic [DIM_W-1:0] w_jlim;
    logic             w_klast, w_jlast, w_ilast, w_end;

    // stage 1: store read data
    logic signed [ELEM_W-1:0] r_a, r_b;
    logic             r_s1_vld, r_s1_first, r_s1_lastk, r_s1_end, r_s1_err;
    logic [IDX_W-1:0] r_s1_row, r_s1_col;
    // stage 2: product
    logic signed [PROD_W-1:0] r_prod;
    logic             r_s2_vld, r_s2_first, r_s2_lastk, r_s2_end, r_s2_err;
    logic [IDX_W-1:0] r_s2_row, r_s2_col;
    // stage 3: accumulator
    logic signed [PROD_W-1:0] w_shift;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  r_acc;
    logic             r_s3_vld, r_s3_end, r_s3_err;
    logic [IDX_W-1:0] r_s3_row, r_s3_col;

    // sizes in force
    assign w_lr   = clamp_dim(i_cfg.left_rows);
    assign w_lc   = clamp_dim(i_cfg.left_cols);
    assign w_rr   = clamp_dim(i_cfg.right_rows);
    assign w_rc   = clamp_dim(i_cfg.right_cols);
    assign w_ltot = CNT_W'(w_lr) * CNT_W'(w_lc);
    assign w_rtot = CNT_W'(w_rr) * CNT_W'(w_rc);

    // loading: surplus left elements dropped, right store stops when full
    assign w_left_wr  = i_cmd.load_left  && (r_lcount < w_ltot);
    assign w_right_wr = i_cmd.load_right && (r_rcount < w_rtot);

    assign o_stat.right_done = (r_rcount >= (w_rtot - CNT_W'(1)));
    assign o_stat.run_end    = w_end;

    // load counters, cleared when a run fires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcount <= '0;
            r_rcount <= '0;
        end else if (i_cmd.start_run) begin
            r_lcount <= '0;
            r_rcount <= '0;
        end else begin
            if (w_left_wr) begin
                r_lcount <= r_lcount + CNT_W'(1);
            end
            if (w_right_wr) begin
                r_rcount <= r_rcount + CNT_W'(1);
            end
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (w_left_wr) begin
            r_left_mem[r_lcount[ADDR_W-1:0]] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_right_wr) begin
            r_right_mem[r_rcount[ADDR_W-1:0]] <= i_value;
        end
    end

    // term sequencer: row i, column j, inner index k (k unused when echoing)
    assign w_lsel       = r_echo ? r_j : r_k;
    assign w_laddr_full = CNT_W'(r_i) * CNT_W'(w_lc) + CNT_W'(w_lsel);
    assign w_raddr_full = CNT_W'(r_k) * CNT_W'(w_rc) + CNT_W'(r_j);
    assign w_jlim       = r_echo ? w_lc : w_rc;
    assign w_klast      = r_echo || (DIM_W'(r_k) == (w_rr - DIM_W'(1)));
    assign w_jlast      = (DIM_W'(r_j) == (w_jlim - DIM_W'(1)));
    assign w_ilast      = (DIM_W'(r_i) == (w_lr - DIM_W'(1)));
    assign w_end        = w_klast && w_jlast && w_ilast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_echo <= 1'b0;
        end else if (i_cmd.start_run) begin
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_echo <= (w_lc != w_rr);
        end else if (i_cmd.step) begin
            if (!w_klast) begin
                r_k <= r_k + IDX_W'(1);
            end else begin
                r_k <= '0;
                if (!w_jlast) begin
                    r_j <= r_j + IDX_W'(1);
                end else begin
                    r_j <= '0;
                    r_i <= w_ilast ? '0 : r_i + IDX_W'(1);
                end
            end
        end
    end

    // stage 1: registered store reads
    always_ff @(posedge i_clk) begin
        r_a <= r_left_mem[w_laddr_full[ADDR_W-1:0]];
        r_b <= r_right_mem[w_raddr_full[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_k == '0);
        r_s1_lastk <= w_klast;
        r_s1_end   <= w_end;
        r_s1_err   <= r_echo;
        r_s1_row   <= r_i;
        r_s1_col   <= r_j;
    end

    // stage 2: product, or the left element lifted to product scale on echo
    always_ff @(posedge i_clk) begin
        if (r_s1_err) begin
            r_prod <= PROD_W'(r_a) <<< FRAC_W;
        end else begin
            r_prod <= PROD_W'(r_a) * PROD_W'(r_b);
        end
        r_s2_first <= r_s1_first;
        r_s2_lastk <= r_s1_lastk;
        r_s2_end   <= r_s1_end;
        r_s2_err   <= r_s1_err;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
    end

    // stage 3: back to Q16.16 by flooring shift, then accumulate
    assign w_shift = r_prod >>> FRAC_W;
    assign w_term  = $signed(w_shift[ACC_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= r_s2_first ? w_term : r_acc + w_term;
        end
        r_s3_end <= r_s2_end;
        r_s3_err <= r_s2_err;
        r_s3_row <= r_s2_row;
        r_s3_col <= r_s2_col;
    end

    // output register with saturation
    always_ff @(posedge i_clk) begin
        if (r_acc > SAT_HI) begin
            o_value_res <= SAT_HI[ELEM_W-1:0];
        end else if (r_acc < SAT_LO) begin
            o_value_res <= SAT_LO[ELEM_W-1:0];
        end else begin
            o_value_res <= r_acc[ELEM_W-1:0];
        end
        o_row_index  <= r_s3_row;
        o_col_index  <= r_s3_col;
        o_size_error <= r_s3_err;
        o_last       <= r_s3_end;
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_s1_vld    <= i_cmd.step;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld && r_s2_lastk;
            o_res_valid <= r_s3_vld;
        end
    end

endmodule : mm_dp

`default_nettype wire

[rtl/core/matrix_multiply.sv]
// matrix_multiply: top level of the small Q16.16 matrix multiplier
// depends on mm_pkg, mm_regs, mm_ctrl and mm_dp
`default_nettype none

// Elements are loaded one per cycle while busy is low: kind 0 fills the
// left matrix and kind 1 the right matrix, each in row-major order, with
// the sizes held in the four size registers. The right element that
// completes the right matrix starts a run and busy is high for the run.
// One shared multiply-accumulate unit takes one product term per cycle, and
// a run steps through left_rows*right_cols*right_rows terms, or through
// left_rows*left_cols elements when left_cols and right_rows differ and the
// left matrix is echoed with size_error set. Results leave row-major, one
// per strobe on o_res_valid, the last one strobed after busy falls.
// The receiver cannot stall: every result must be taken in the cycle it
// is strobed. Loading for the next run may begin as soon as busy falls.
module matrix_multiply #(
    parameter  int MAX_DIM = 4,
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_kind,
    input  logic signed [mm_pkg::ELEM_W-1:0]  i_value,
    // results
    output logic                              o_res_valid,
    output logic signed [mm_pkg::ELEM_W-1:0]  o_value_res,
    output logic [IDX_W-1:0]                  o_row_index,
    output logic [IDX_W-1:0]                  o_col_index,
    output logic                              o_size_error,
    output logic                              o_last,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mm_pkg::PADDR_W-1:0]        paddr,
    input  logic [mm_pkg::PDATA_W-1:0]        pwdata,
    output logic [mm_pkg::PDATA_W-1:0]        prdata,
    output logic                              pready
);
    import mm_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // size registers
    mm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // controller
    mm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // datapath
    mm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_res_valid  (o_res_valid),
        .o_value_res  (o_value_res),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_size_error (o_size_error),
        .o_last       (o_last)
    );

endmodule : matrix_multiply

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for the matrix_multiply Q16.16 block
// holds an element-level scoreboard with its own multiply/echo predictor;
// depends on mm_pkg and the matrix_multiply RTL only

localparam int MM_DIM   = 4;
localparam int MM_DEPTH = MM_DIM * MM_DIM;

// one element of a product or echo run
typedef struct packed {
    logic signed [mm_pkg::ELEM_W-1:0] value;
    logic [1:0]                       row;
    logic [1:0]                       col;
    logic                             size_error;
    logic                             last;
} mm_result_t;

// predicts every run from the accepted elements and checks results in order
class mm_scoreboard;
    logic [mm_pkg::CFG_W-1:0]         size_reg [4];
    logic signed [mm_pkg::ELEM_W-1:0] left_mem [MM_DEPTH];
    logic signed [mm_pkg::ELEM_W-1:0] right_mem [MM_DEPTH];
    int                               left_fill;
    int                               right_fill;
    mm_result_t                       owed_elems [$];
    int n_items, n_ignored, n_results, n_errors;
    int n_products, n_echoes, n_saturated, n_writes;

    function new();
        foreach (size_reg[i]) size_reg[i] = mm_pkg::CFG_RESET;
        foreach (left_mem[i]) left_mem[i] = '0;
        foreach (right_mem[i]) right_mem[i] = '0;
        left_fill  = 0;
        right_fill = 0;
    endfunction

    // zero is taken as one, anything above the maximum as the maximum
    function int dim(input mm_pkg::t_cfg_idx idx);
        if (size_reg[idx] == 0) return 1;
        if (size_reg[idx] > MM_DIM) return MM_DIM;
        return int'(size_reg[idx]);
    endfunction

    function int left_total();
        return dim(mm_pkg::CFG_LEFT_ROWS) * dim(mm_pkg::CFG_LEFT_COLS);
    endfunction

    function int right_total();
        return dim(mm_pkg::CFG_RIGHT_ROWS) * dim(mm_pkg::CFG_RIGHT_COLS);
    endfunction

    function int pending();
        return owed_elems.size();
    endfunction

    function void set_size(input mm_pkg::t_cfg_idx idx, input logic [mm_pkg::CFG_W-1:0] v);
        size_reg[idx] = v;
        n_writes++;
    endfunction

    // product (or echo of the left matrix) with the sizes in force now
    function void run_matrix();
        int lr, lc, rr, rc;
        logic signed [63:0] acc, a, b;
        mm_result_t r;
        lr = dim(mm_pkg::CFG_LEFT_ROWS);
        lc = dim(mm_pkg::CFG_LEFT_COLS);
        rr = dim(mm_pkg::CFG_RIGHT_ROWS);
        rc = dim(mm_pkg::CFG_RIGHT_COLS);
        if (lc != rr) begin
            n_echoes++;
            for (int i = 0; i < lr; i++) begin
                for (int j = 0; j < lc; j++) begin
                    r.value      = left_mem[(i * lc + j) % MM_DEPTH];
                    r.row        = 2'(i);
                    r.col        = 2'(j);
                    r.size_error = 1'b1;
                    r.last       = (i == lr - 1) && (j == lc - 1);
                    owed_elems.push_back(r);
                end
            end
        end else begin
            n_products++;
            for (int i = 0; i < lr; i++) begin
                for (int j = 0; j < rc; j++) begin
                    acc = '0;
                    for (int k = 0; k < rr; k++) begin
                        a = left_mem[(i * lc + k) % MM_DEPTH];
                        b = right_mem[(k * rc + j) % MM_DEPTH];
                        // each term back to Q16.16, rounding toward minus infinity
                        acc += (a * b) >>> 16;
                    end
                    if (acc > 64'sd2147483647) begin
                        r.value = 32'h7FFF_FFFF;
                        n_saturated++;
                    end else if (acc < -64'sd2147483648) begin
                        r.value = 32'h8000_0000;
                        n_saturated++;
                    end else begin
                        r.value = acc[31:0];
                    end
                    r.row        = 2'(i);
                    r.col        = 2'(j);
                    r.size_error = 1'b0;
                    r.last       = (i == lr - 1) && (j == rc - 1);
                    owed_elems.push_back(r);
                end
            end
        end
        left_fill  = 0;
        right_fill = 0;
    endfunction

    // an element taken by the block
    function void note_element(input logic kind, input logic signed [mm_pkg::ELEM_W-1:0] v);
        n_items++;
        if (kind == mm_pkg::KIND_LEFT) begin
            if (left_fill < left_total()) begin
                left_mem[left_fill] = v;
                left_fill++;
            end else begin
                n_ignored++;
            end
        end else begin
            // a stale count (sizes shrank) stores nothing and fires at once
            if (right_fill < right_total()) begin
                right_mem[right_fill] = v;
                right_fill++;
            end
            if (right_fill >= right_total()) run_matrix();
        end
    endfunction

    // a result strobed by the block, against the oldest owed element
    function void check_result(input mm_result_t seen);
        mm_result_t due;
        n_results++;
        if (owed_elems.size() == 0) begin
            $error("unexpected result: value_res %0d row_index %0d col_index %0d",
                   seen.value, seen.row, seen.col);
            n_errors++;
        end else begin
            due = owed_elems.pop_front();
            if (seen.value !== due.value) begin
                $error("value_res: expected %0d, got %0d", due.value, seen.value);
                n_errors++;
            end
            if (seen.row !== due.row) begin
                $error("row_index: expected %0d, got %0d", due.row, seen.row);
                n_errors++;
            end
            if (seen.col !== due.col) begin
                $error("col_index: expected %0d, got %0d", due.col, seen.col);
                n_errors++;
            end
            if (seen.size_error !== due.size_error) begin
                $error("size_error: expected %0b, got %0b", due.size_error, seen.size_error);
                n_errors++;
            end
            if (seen.last !== due.last) begin
                $error("last: expected %0b, got %0b", due.last, seen.last);
                n_errors++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int ITEM_TARGET = 450;
    localparam int STALL_LIMIT = 2000;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_kind;
    logic signed [mm_pkg::ELEM_W-1:0]   i_value;
    logic                               o_res_valid;
    logic signed [mm_pkg::ELEM_W-1:0]   o_value_res;
    logic [1:0]                         o_row_index;
    logic [1:0]                         o_col_index;
    logic                               o_size_error;
    logic                               o_last;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [mm_pkg::PADDR_W-1:0]         paddr;
    logic [mm_pkg::PDATA_W-1:0]         pwdata;
    logic [mm_pkg::PDATA_W-1:0]         prdata;
    logic                               pready;

    mm_scoreboard sb;
    mm_result_t   seen_elem;
    int           gap_max;
    int           stall_cycles;

    matrix_multiply #(.MAX_DIM(MM_DIM)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .o_res_valid  (o_res_valid),
        .o_value_res  (o_value_res),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_size_error (o_size_error),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1) begin
            seen_elem.value      = o_value_res;
            seen_elem.row        = o_row_index;
            seen_elem.col        = o_col_index;
            seen_elem.size_error = o_size_error;
            seen_elem.last       = o_last;
            sb.check_result(seen_elem);
        end
    end

    // watchdog: cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && !busy) || o_res_valid === 1'b1 || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // corner values of a Q16.16 element
    function automatic logic signed [31:0] corner_value(input int n);
        case (n % 7)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            5:       return 32'hFFFF_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // mostly modest magnitudes, some full range, some corners
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0:       v = corner_value($urandom_range(0, 6));
            1, 2:    v = $urandom;
            default: begin
                v = $urandom_range(0, 32'h3FFFF);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    // size register value, now and then zero or above the maximum
    function automatic logic [2:0] pick_size();
        case ($urandom_range(0, 11))
            0:       return 3'd0;
            1:       return 3'($urandom_range(5, 7));
            default: return 3'($urandom_range(1, 4));
        endcase
    endfunction

    // one element transaction after a random gap
    task automatic feed_element(input logic kind, input logic signed [31:0] val);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_kind  <= kind;
        i_value <= val;
        do @(posedge i_clk); while (busy);
        sb.note_element(kind, val);
    endtask

    // stop sending and let every owed result come out
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write a size register, upper data bits random, then read it back
    task automatic write_size(input mm_pkg::t_cfg_idx idx, input logic [2:0] size);
        logic [31:0] data;
        data      = $urandom;
        data[2:0] = size;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_size(idx, size);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[mm_pkg::CFG_W-1:0] !== size) begin
            $error("register %0d readback: expected %0d, got %0d", idx, size,
                   prdata[mm_pkg::CFG_W-1:0]);
            sb.n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_sizes();
        logic [2:0] lr, lc, rr, rc;
        lr = pick_size();
        lc = pick_size();
        // inner sizes mostly agree so that most runs multiply
        rr = ($urandom_range(0, 4) != 0) ? lc : pick_size();
        rc = pick_size();
        write_size(mm_pkg::CFG_LEFT_ROWS, lr);
        write_size(mm_pkg::CFG_LEFT_COLS, lc);
        write_size(mm_pkg::CFG_RIGHT_ROWS, rr);
        write_size(mm_pkg::CFG_RIGHT_COLS, rc);
    endtask

    // load what the current sizes still need (the left count now and then cut or padded),
    // left and right interleaved, the last right element after every left one; stops early after cut
    task automatic load_matrices(input int cut);
        int lneed, rneed, sent;
        lneed = sb.left_total() - sb.left_fill;
        if (lneed < 0) lneed = 0;
        if ($urandom_range(0, 9) == 0) lneed = $urandom_range(0, lneed);
        else if ($urandom_range(0, 9) == 0) lneed += $urandom_range(1, 3);
        rneed = (sb.right_fill >= sb.right_total()) ? 1 : sb.right_total() - sb.right_fill;
        sent  = 0;
        while (rneed > 0 && sent < cut) begin
            if (lneed > 0 && (rneed == 1 || $urandom_range(0, 1) == 1)) begin
                feed_element(mm_pkg::KIND_LEFT, pick_value());
                lneed--;
            end else begin
                feed_element(mm_pkg::KIND_RIGHT, pick_value());
                rneed--;
            end
            sent++;
        end
    endtask

    initial begin
        int  base_items;
        int  sel;
        bit  resize_next;
        sb           = new();
        start        = 1'b0;
        i_kind       = 1'b0;
        i_value      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        stall_cycles = 0;
        gap_max      = 2;
        resize_next  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full 4x4 left of corner values plus one surplus, times a 4x1 right
        write_size(mm_pkg::CFG_LEFT_ROWS, 3'd4);
        write_size(mm_pkg::CFG_LEFT_COLS, 3'd4);
        write_size(mm_pkg::CFG_RIGHT_ROWS, 3'd4);
        write_size(mm_pkg::CFG_RIGHT_COLS, 3'd1);
        for (int n = 0; n < 17; n++) feed_element(mm_pkg::KIND_LEFT, corner_value(n));
        for (int n = 0; n < 4; n++) feed_element(mm_pkg::KIND_RIGHT, corner_value(n + 3));

        // zero and oversized registers, inner sizes disagree, no new left
        wait_drained();
        write_size(mm_pkg::CFG_LEFT_ROWS, 3'd0);
        write_size(mm_pkg::CFG_LEFT_COLS, 3'd7);
        write_size(mm_pkg::CFG_RIGHT_ROWS, 3'd2);
        write_size(mm_pkg::CFG_RIGHT_COLS, 3'd0);
        feed_element(mm_pkg::KIND_RIGHT, corner_value(1));
        feed_element(mm_pkg::KIND_RIGHT, corner_value(0));

        // right matrix shrinks under a partial load, next right fires at once
        wait_drained();
        write_size(mm_pkg::CFG_LEFT_ROWS, 3'd1);
        write_size(mm_pkg::CFG_LEFT_COLS, 3'd1);
        write_size(mm_pkg::CFG_RIGHT_ROWS, 3'd2);
        write_size(mm_pkg::CFG_RIGHT_COLS, 3'd2);
        feed_element(mm_pkg::KIND_RIGHT, 32'h0002_8000);
        feed_element(mm_pkg::KIND_RIGHT, 32'hFFFE_0000);
        wait_drained();
        write_size(mm_pkg::CFG_RIGHT_ROWS, 3'd1);
        write_size(mm_pkg::CFG_RIGHT_COLS, 3'd1);
        feed_element(mm_pkg::KIND_RIGHT, 32'h1234_5678);
        wait_drained();

        // random jobs: mostly whole loads, some cut short, some noise
        base_items = sb.n_items - sb.n_ignored;
        while (sb.n_items - sb.n_ignored - base_items < ITEM_TARGET) begin
            sel = $urandom_range(0, 9);
            if (sel < 3 || resize_next) begin
                wait_drained();
                random_sizes();
                resize_next = 1'b0;
            end
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 14;
            endcase
            if (sel == 9) begin
                repeat ($urandom_range(1, 6))
                    feed_element(1'($urandom_range(0, 1)), pick_value());
            end else if (sel == 8) begin
                load_matrices($urandom_range(1, 6));
                resize_next = 1'b1;
            end else begin
                load_matrices(1000);
            end
        end

        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("%0d elements taken (%0d surplus ignored), %0d products, %0d echoes",
                 sb.n_items, sb.n_ignored, sb.n_products, sb.n_echoes);
        $display("%0d result elements checked, %0d saturated, %0d size register writes",
                 sb.n_results, sb.n_saturated, sb.n_writes);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
